FILE: rtl/rdh_pkg.sv
package rdh_pkg;

  localparam logic [1:0] REG_RADIUS        = 2'd0;
  localparam logic [1:0] REG_CENTER_SECOND = 2'd1;
  localparam logic [1:0] REG_CENTER_THIRD  = 2'd2;
  localparam logic [1:0] REG_DIMS_IN_USE   = 2'd3;

  localparam logic [30:0] RADIUS_RESET = 31'd9830;
  localparam logic [1:0]  DIMS_RESET   = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic valid;
    logic inc;
  } bin_op_t;

  typedef struct packed {
    logic busy;
  } bin_stat_t;

endpackage

FILE: rtl/radial_distance_histogram.sv
// Histogram of particle distances from the central axis of the domain.
// Input channel (in_valid_i/in_ready_o): a sample item carries the second and
// third coordinates and a movable flag; a read item selects one bin. Output
// channel (out_valid_o/out_ready_i): one item per read, with the bin index and
// its saturating count. Samples produce no output item.
// A movable sample holds in_ready_o low until it is done, mostly in the 31-step
// square root and the restoring division on the shared add/subtract unit.
// Samples rejected early finish sooner; an immovable sample never leaves idle.
// A read of a bin in range reads the bin in ST_RD and registers the result in
// ST_RDW; a read of a bin out of range registers a zero count in ST_RD. Both
// wait in ST_RD until the output register is free, and the block takes the
// next item as the result is shown. A waiting result does not stop sample
// items. After reset the bins are cleared one per cycle, and in_ready_o stays
// low until every bin is clear. Configuration writes go over the APB port to
// radius, center_second, center_third and dims_in_use; the user must make them
// only while no item is in flight, which the block itself does not enforce.
module radial_distance_histogram
  import rdh_pkg::*;
#(
  parameter int NUM_BINS = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] pos_second_i,
  input  logic [31:0] pos_third_i,
  input  logic        movable_i,
  input  logic [6:0]  bin_select_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  bin_index_o,
  output logic [31:0] bin_count_o
);

  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  logic [30:0]      radius_q;
  logic [31:0]      center_second_q;
  logic [31:0]      center_third_q;
  logic [1:0]       dims_q;
  logic             wr_en;
  bin_op_t          bin_op;
  bin_stat_t        bin_stat;
  logic [BIN_W-1:0] bin_addr;
  logic [31:0]      bin_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q        <= RADIUS_RESET;
      center_second_q <= '0;
      center_third_q  <= '0;
      dims_q          <= DIMS_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_RADIUS:        radius_q        <= pwdata[30:0];
        REG_CENTER_SECOND: center_second_q <= pwdata;
        REG_CENTER_THIRD:  center_third_q  <= pwdata;
        REG_DIMS_IN_USE:   dims_q          <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RADIUS:        prdata = 32'(radius_q);
      REG_CENTER_SECOND: prdata = center_second_q;
      REG_CENTER_THIRD:  prdata = center_third_q;
      REG_DIMS_IN_USE:   prdata = 32'(dims_q);
      default:           prdata = '0;
    endcase
  end

  rdh_core #(
    .NUM_BINS (NUM_BINS),
    .BIN_W    (BIN_W)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .pos_second_i    (pos_second_i),
    .pos_third_i     (pos_third_i),
    .movable_i       (movable_i),
    .bin_select_i    (bin_select_i),
    .radius_i        (radius_q),
    .center_second_i (center_second_q),
    .center_third_i  (center_third_q),
    .dims_i          (dims_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bin_index_o     (bin_index_o),
    .bin_count_o     (bin_count_o),
    .bin_op_o        (bin_op),
    .bin_addr_o      (bin_addr),
    .bin_stat_i      (bin_stat),
    .bin_data_i      (bin_data)
  );

  rdh_bins #(
    .NUM_BINS (NUM_BINS),
    .BIN_W    (BIN_W)
  ) u_bins (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (bin_op),
    .addr_i    (bin_addr),
    .stat_o    (bin_stat),
    .rd_data_o (bin_data)
  );

endmodule

FILE: rtl/rdh_mul.sv
module rdh_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: rtl/rdh_alu.sv
module rdh_alu (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        sub_i,
  output logic [63:0] sum_o,
  output logic        ge_o
);

  logic [64:0] full;
  logic [63:0] b_op;

  assign b_op  = sub_i ? ~b_i : b_i;
  assign full  = {1'b0, a_i} + {1'b0, b_op} + 65'(sub_i);
  assign sum_o = full[63:0];
  assign ge_o  = full[64];

endmodule

FILE: rtl/rdh_bins.sv
module rdh_bins
  import rdh_pkg::*;
#(
  parameter int NUM_BINS = 100,
  parameter int BIN_W    = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bin_op_t          op_i,
  input  logic [BIN_W-1:0] addr_i,
  output bin_stat_t        stat_o,
  output logic [31:0]      rd_data_o
);

  logic [31:0]      mem [NUM_BINS];
  logic [31:0]      rd_q;
  logic [BIN_W-1:0] addr_q;
  logic [BIN_W-1:0] clr_cnt_q;
  logic             clr_q;
  bin_op_t          op_q;
  logic             wr_en;

  assign wr_en = op_q.valid && op_q.inc && (rd_q != CNT_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      op_q      <= '0;
    end else begin
      op_q <= op_i;
      if (clr_q) begin
        if (clr_cnt_q == BIN_W'(NUM_BINS - 1)) begin
          clr_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_en) begin
      mem[addr_q] <= rd_q + 32'd1;
    end
    if (op_i.valid) begin
      rd_q   <= mem[addr_i];
      addr_q <= addr_i;
    end
  end

  assign stat_o.busy = clr_q;
  assign rd_data_o   = rd_q;

endmodule

FILE: rtl/rdh_core.sv
module rdh_core
  import rdh_pkg::*;
#(
  parameter int NUM_BINS = 100,
  parameter int BIN_W    = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  input  logic [31:0]      pos_second_i,
  input  logic [31:0]      pos_third_i,
  input  logic             movable_i,
  input  logic [6:0]       bin_select_i,
  input  logic [30:0]      radius_i,
  input  logic [31:0]      center_second_i,
  input  logic [31:0]      center_third_i,
  input  logic [1:0]       dims_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [6:0]       bin_index_o,
  output logic [31:0]      bin_count_o,
  output bin_op_t          bin_op_o,
  output logic [BIN_W-1:0] bin_addr_o,
  input  bin_stat_t        bin_stat_i,
  input  logic [31:0]      bin_data_i
);

  localparam int CW = (BIN_W > 1) ? $clog2(BIN_W) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MR2   = 4'd1;
  localparam logic [3:0] ST_MA2   = 4'd2;
  localparam logic [3:0] ST_MA3   = 4'd3;
  localparam logic [3:0] ST_CA3   = 4'd4;
  localparam logic [3:0] ST_ADD   = 4'd5;
  localparam logic [3:0] ST_CMPS  = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_MULB  = 4'd8;
  localparam logic [3:0] ST_DIVL  = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_BINRD = 4'd11;
  localparam logic [3:0] ST_RD    = 4'd12;
  localparam logic [3:0] ST_RDW   = 4'd13;

  logic [3:0]       state_q, state_d;
  logic [31:0]      mag2_q, mag3_q;
  logic [63:0]      r2_q, s_q, a3_q, res_q, bit_q, dvs_q;
  logic [BIN_W-1:0] quo_q;
  logic [CW-1:0]    cnt_q;
  logic [6:0]       sel_q;
  logic             sel_ok_q;
  logic             out_valid_q;
  logic [6:0]       out_index_q;
  logic [31:0]      out_count_q;

  logic [32:0]        diff2, diff3;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [63:0]        alu_a, alu_b, alu_sum;
  logic               alu_sub, alu_ge;
  logic               accept, out_free, dims_ge2, dims_ge3;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign dims_ge2 = dims_i[1];
  assign dims_ge3 = (dims_i == 2'd3);

  assign diff2 = {pos_second_i[31], pos_second_i} - {center_second_i[31], center_second_i};
  assign diff3 = {pos_third_i[31], pos_third_i} - {center_third_i[31], center_third_i};

  rdh_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  rdh_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .ge_o  (alu_ge)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MR2: begin
        mul_a = 32'(radius_i);
        mul_b = 32'(radius_i);
      end
      ST_MA2: begin
        mul_a = mag2_q;
        mul_b = mag2_q;
      end
      ST_MA3: begin
        mul_a = mag3_q;
        mul_b = mag3_q;
      end
      ST_MULB: begin
        mul_a = res_q[31:0];
        mul_b = 32'(NUM_BINS);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_MA3, ST_CA3: begin
        alu_a   = prod;
        alu_b   = r2_q;
        alu_sub = 1'b1;
      end
      ST_ADD: begin
        alu_a = s_q;
        alu_b = a3_q;
      end
      ST_CMPS: begin
        alu_a   = s_q;
        alu_b   = r2_q;
        alu_sub = 1'b1;
      end
      ST_SQRT: begin
        alu_a   = s_q;
        alu_b   = res_q | bit_q;
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = s_q;
        alu_b   = dvs_q;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_READ) begin
            state_d = ST_RD;
          end else if (movable_i) begin
            state_d = ST_MR2;
          end
        end
      end
      ST_MR2:  state_d = ST_MA2;
      ST_MA2:  state_d = ST_MA3;
      ST_MA3:  state_d = (dims_ge2 && alu_ge) ? ST_IDLE : ST_CA3;
      ST_CA3:  state_d = (dims_ge3 && alu_ge) ? ST_IDLE : ST_ADD;
      ST_ADD:  state_d = ST_CMPS;
      ST_CMPS: state_d = alu_ge ? ST_IDLE : ST_SQRT;
      ST_SQRT: state_d = bit_q[0] ? ST_MULB : ST_SQRT;
      ST_MULB: state_d = ST_DIVL;
      ST_DIVL: state_d = ST_DIV;
      ST_DIV:  state_d = (cnt_q == '0) ? ST_BINRD : ST_DIV;
      ST_BINRD: state_d = ST_IDLE;
      ST_RD: begin
        if (out_free) begin
          state_d = sel_ok_q ? ST_RDW : ST_IDLE;
        end
      end
      ST_RDW:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_RD && out_free && !sel_ok_q) || state_q == ST_RDW) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mag2_q   <= diff2[32] ? 32'(-diff2) : diff2[31:0];
        mag3_q   <= diff3[32] ? 32'(-diff3) : diff3[31:0];
        sel_q    <= bin_select_i;
        sel_ok_q <= (32'(bin_select_i) < 32'(NUM_BINS));
      end
      ST_MA2: r2_q <= prod;
      ST_MA3: s_q <= dims_ge2 ? prod : '0;
      ST_CA3: a3_q <= dims_ge3 ? prod : '0;
      ST_ADD: s_q <= alu_sum;
      ST_CMPS: begin
        res_q <= '0;
        bit_q <= 64'(1) << 60;
      end
      ST_SQRT: begin
        if (alu_ge) begin
          s_q   <= alu_sum;
          res_q <= (res_q >> 1) | bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_DIVL: begin
        s_q   <= prod;
        dvs_q <= 64'(radius_i) << (BIN_W - 1);
        cnt_q <= CW'(BIN_W - 1);
        quo_q <= '0;
      end
      ST_DIV: begin
        if (alu_ge) begin
          s_q <= alu_sum;
        end
        quo_q <= BIN_W'({quo_q, alu_ge});
        dvs_q <= dvs_q >> 1;
        cnt_q <= cnt_q - 1'b1;
      end
      ST_RD: begin
        if (out_free && !sel_ok_q) begin
          out_index_q <= sel_q;
          out_count_q <= '0;
        end
      end
      ST_RDW: begin
        out_index_q <= sel_q;
        out_count_q <= bin_data_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    bin_op_o   = '0;
    bin_addr_o = quo_q;
    if (state_q == ST_BINRD) begin
      bin_op_o.valid = 1'b1;
      bin_op_o.inc   = 1'b1;
    end else if (state_q == ST_RD) begin
      bin_op_o.valid = out_free && sel_ok_q;
      bin_addr_o     = BIN_W'(sel_q);
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE) && !bin_stat_i.busy;
  assign out_valid_o = out_valid_q;
  assign bin_index_o = out_index_q;
  assign bin_count_o = out_count_q;

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rdh_pkg::*;

  localparam int NUM_BINS = 100;
  localparam int SETTLE_CYCLES = 64;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic        kind;
    logic [31:0] pos_second;
    logic [31:0] pos_third;
    logic        movable;
    logic [6:0]  bin_select;
  } hist_item_t;

  typedef struct packed {
    logic [6:0]  index;
    logic [31:0] count;
  } bin_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [31:0] pos_second_i;
  logic [31:0] pos_third_i;
  logic        movable_i;
  logic [6:0]  bin_select_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [6:0]  bin_index_o;
  logic [31:0] bin_count_o;

  hist_item_t  stim_q[$];
  bin_report_t report_q[$];
  logic [31:0] hist_count [NUM_BINS];
  logic [30:0] cfg_radius;
  logic [31:0] cfg_center_second;
  logic [31:0] cfg_center_third;
  logic [1:0]  cfg_dims;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int          mismatches;
  logic        in_fire;

  radial_distance_histogram #(
    .NUM_BINS(NUM_BINS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .pos_second_i(pos_second_i),
    .pos_third_i (pos_third_i),
    .movable_i   (movable_i),
    .bin_select_i(bin_select_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bin_index_o (bin_index_o),
    .bin_count_o (bin_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic longint unsigned floor_root(longint unsigned s);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= s) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic longint unsigned axis_square(logic [31:0] p, logic [31:0] c);
    longint          d;
    longint unsigned m;
    d = longint'(signed'(p)) - longint'(signed'(c));
    m = (d < 0) ? -d : d;
    return m * m;
  endfunction

  task automatic add_stim(hist_item_t it);
    stim_q.insert(stim_q.size(), it);
  endtask

  task automatic absorb_item(hist_item_t it);
    longint unsigned r2;
    longint unsigned s;
    longint unsigned a;
    longint unsigned q;
    longint unsigned b;
    bit              inside_radius;
    bin_report_t     rep;
    if (it.kind == KIND_READ) begin
      rep.index = it.bin_select;
      if (it.bin_select < NUM_BINS) begin
        rep.count = hist_count[it.bin_select];
      end else begin
        rep.count = 32'd0;
      end
      report_q.insert(report_q.size(), rep);
      return;
    end
    if (!it.movable) begin
      return;
    end
    r2 = longint'(cfg_radius) * longint'(cfg_radius);
    s = 0;
    inside_radius = 1'b1;
    if (cfg_dims >= 2) begin
      a = axis_square(it.pos_second, cfg_center_second);
      if (a >= r2) begin
        inside_radius = 1'b0;
      end
      s = a;
    end
    if (cfg_dims >= 3 && inside_radius) begin
      a = axis_square(it.pos_third, cfg_center_third);
      if (a >= r2) begin
        inside_radius = 1'b0;
      end
      s += a;
    end
    if (inside_radius && s < r2 && cfg_radius != 0) begin
      q = floor_root(s);
      b = (q * NUM_BINS) / longint'(cfg_radius);
      if (b < NUM_BINS && hist_count[b] != CNT_MAX) begin
        hist_count[b]++;
      end
    end
  endtask

  task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor_b
    bin_report_t want;
    hist_item_t  seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (report_q.size() == 0) begin
          note_mismatch("unrequested bin report, index", 64'd0, 64'(bin_index_o));
        end else begin
          want = report_q.pop_front();
          if (bin_index_o !== want.index) begin
            note_mismatch("bin_index", 64'(want.index), 64'(bin_index_o));
          end
          if (bin_count_o !== want.count) begin
            note_mismatch("bin_count", 64'(want.count), 64'(bin_count_o));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        seen.kind = kind_i;
        seen.pos_second = pos_second_i;
        seen.pos_third = pos_third_i;
        seen.movable = movable_i;
        seen.bin_select = bin_select_i;
        absorb_item(seen);
      end
    end
    in_fire <= rst_ni && in_valid_i && in_ready_o;
  end

  always @(negedge clk_i) begin : driver_b
    hist_item_t nxt;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = stim_q.pop_front();
        in_valid_i <= 1'b1;
        kind_i <= nxt.kind;
        pos_second_i <= nxt.pos_second;
        pos_third_i <= nxt.pos_third;
        movable_i <= nxt.movable;
        bin_select_i <= nxt.bin_select;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_RADIUS:        cfg_radius = val[30:0];
      REG_CENTER_SECOND: cfg_center_second = val;
      REG_CENTER_THIRD:  cfg_center_third = val;
      REG_DIMS_IN_USE:   cfg_dims = val[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain_histogram();
    while (stim_q.size() != 0 || in_valid_i || report_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic hist_item_t make_item(logic kind, logic [31:0] p2, logic [31:0] p3,
                                           logic mov, logic [6:0] sel);
    hist_item_t it;
    it.kind = kind;
    it.pos_second = p2;
    it.pos_third = p3;
    it.movable = mov;
    it.bin_select = sel;
    return it;
  endfunction

  function automatic logic [31:0] jitter(logic [31:0] c, logic [30:0] span);
    logic [31:0] off;
    off = $urandom_range(span);
    return $urandom_range(1) ? c - off : c + off;
  endfunction

  function automatic hist_item_t random_item();
    hist_item_t  it;
    int unsigned roll;
    logic [31:0] off;
    roll = $urandom_range(99);
    it = make_item(KIND_SAMPLE, $urandom, $urandom, $urandom_range(9) != 0,
                   7'($urandom_range(127)));
    if (roll < 30) begin
      it.kind = KIND_READ;
      if (roll < 26) begin
        it.bin_select = 7'($urandom_range(NUM_BINS - 1));
      end
    end else if (roll < 80) begin
      it.pos_second = jitter(cfg_center_second, cfg_radius);
      it.pos_third = jitter(cfg_center_third, cfg_radius);
    end else if (roll < 90) begin
      off = {1'b0, cfg_radius} + $urandom_range(2) - 1;
      it.pos_second = $urandom_range(1) ? cfg_center_second - off : cfg_center_second + off;
      it.pos_third = $urandom_range(1) ? cfg_center_third : jitter(cfg_center_third, 31'd4);
    end
    return it;
  endfunction

  initial begin : stimulus_b
    logic [31:0] ph_radius [NUM_PHASES];
    logic [31:0] ph_c2 [NUM_PHASES];
    logic [31:0] ph_c3 [NUM_PHASES];
    logic [31:0] ph_dims [NUM_PHASES];
    int unsigned ph_idle [NUM_PHASES];
    int unsigned ph_stall [NUM_PHASES];
    int unsigned ph_items [NUM_PHASES];

    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_SAMPLE;
    pos_second_i = '0;
    pos_third_i = '0;
    movable_i = 1'b0;
    bin_select_i = '0;
    out_ready_i = 1'b0;
    in_fire = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    cfg_radius = RADIUS_RESET;
    cfg_center_second = '0;
    cfg_center_third = '0;
    cfg_dims = DIMS_RESET;
    foreach (hist_count[i]) hist_count[i] = '0;

    ph_radius = '{32'd9830, 32'hFFFF_FFFF, 32'h8000_0001, $urandom_range(32'h0010_0000, 1),
                  32'h8000_0000, $urandom_range(32'h7FFF_FFFF, 1), 32'd6553600,
                  $urandom_range(32'h7FFF_FFFF, 1)};
    ph_c2 = '{32'd0, 32'h8000_0000, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom};
    ph_c3 = '{32'd0, 32'h7FFF_FFFF, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom};
    ph_dims = '{32'd2, 32'hFFFF_FFFF, 32'd3, 32'd1, 32'd3, 32'hFFFF_FFFC, 32'd3, 32'd2};
    ph_idle = '{0, 86, 0, 28, 0, 86, 0, 28};
    ph_stall = '{0, 0, 86, 28, 0, 0, 86, 28};
    ph_items = '{200, 200, 200, 200, 50, 50, 200, 200};

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: radius about 0.15, centered, two dimensions in use.
    add_stim(make_item(KIND_SAMPLE, 32'd0, 32'd0, 1'b1, 7'd127));
    add_stim(make_item(KIND_SAMPLE, 32'd9829, 32'hFFFF_FFFF, 1'b1, 7'd0));
    add_stim(make_item(KIND_SAMPLE, -32'sd9829, 32'd0, 1'b1, 7'd0));
    add_stim(make_item(KIND_SAMPLE, 32'd9830, 32'd0, 1'b1, 7'd0));
    add_stim(make_item(KIND_SAMPLE, -32'sd9830, 32'd0, 1'b1, 7'd0));
    add_stim(make_item(KIND_SAMPLE, 32'h7FFF_FFFF, 32'd0, 1'b1, 7'd0));
    add_stim(make_item(KIND_SAMPLE, 32'h8000_0000, 32'd0, 1'b1, 7'd0));
    add_stim(make_item(KIND_SAMPLE, 32'd0, 32'd0, 1'b0, 7'd0));
    add_stim(make_item(KIND_SAMPLE, 32'd100, 32'h8000_0000, 1'b1, 7'd0));
    add_stim(make_item(KIND_SAMPLE, 32'd0, 32'h7FFF_FFFF, 1'b1, 7'd0));
    add_stim(make_item(KIND_SAMPLE, 32'd4915, 32'd0, 1'b1, 7'd0));
    add_stim(make_item(KIND_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 7'd0));
    add_stim(make_item(KIND_READ, 32'd0, 32'd0, 1'b0, 7'd50));
    add_stim(make_item(KIND_READ, 32'd0, 32'd0, 1'b0, 7'd99));
    add_stim(make_item(KIND_READ, 32'd0, 32'd0, 1'b0, 7'd100));
    add_stim(make_item(KIND_READ, 32'd0, 32'd0, 1'b0, 7'd127));
    add_stim(make_item(KIND_READ, 32'd0, 32'd0, 1'b0, 7'd1));
    drain_histogram();

    for (int p = 0; p < NUM_PHASES; p++) begin
      reg_write(REG_RADIUS, ph_radius[p]);
      reg_write(REG_CENTER_SECOND, ph_c2[p]);
      reg_write(REG_CENTER_THIRD, ph_c3[p]);
      reg_write(REG_DIMS_IN_USE, ph_dims[p]);
      idle_pct = ph_idle[p];
      stall_pct = ph_stall[p];
      @(posedge clk_i);
      for (int n = 0; n < ph_items[p]; n++) begin
        add_stim(random_item());
      end
      drain_histogram();
    end

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rdh_pkg.sv
rtl/rdh_mul.sv
rtl/rdh_alu.sv
rtl/rdh_bins.sv
rtl/rdh_core.sv
rtl/radial_distance_histogram.sv
dv/tb_top.sv
